// File: rtl/core/ntc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared constants for the NTC thermistor beta-equation converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

  // Register indexes
  localparam logic [2:0] REG_BETA  = 3'd0;
  localparam logic [2:0] REG_RNOM  = 3'd1;
  localparam logic [2:0] REG_SCALE = 3'd2;
  localparam logic [2:0] REG_RDIV  = 3'd3;
  localparam logic [2:0] REG_TREF  = 3'd4;

  // Register reset values
  localparam logic [15:0] BETA_RST  = 16'd3950;
  localparam logic [15:0] RNOM_RST  = 16'd10000;
  localparam logic [15:0] SCALE_RST = 16'd1024;
  localparam logic [15:0] RDIV_RST  = 16'd10000;
  localparam logic [15:0] TREF_RST  = 16'd29815;

  // Log unit
  localparam int          LOG_FRAC_BITS = 28;
  localparam int          LN_FRAC_BITS  = 24;
  localparam logic [29:0] LN2_Q30       = 30'd744261118;

  // Quotient width below the saturation bit
  localparam int          QBITS = 16;

endpackage

// File: rtl/core/ntc_thermistor_to_temperature_top.sv
`timescale 1ns / 1ps
// Throughput: one sample per cycle; the pipeline holds as a whole only while
// a finished result is stalled at the output register.
// Reset (rst_n, synchronous, active low) empties the pipeline and loads the
// register defaults; the pipeline is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
// ntc_thermistor_to_temperature_top
// NTC thermistor ADC sample to temperature in 0.1 K via the beta equation:
// divider resistance, two pipelined binary logs by squaring, restoring divide.
// ----------------------------------------------------------------------------
module ntc_thermistor_to_temperature_top #(
  parameter int ADC_FULL_SCALE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [9:0]  in_adc_sample,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_temp_decikelvin,
  output logic        out_status,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int FSW = $clog2(ADC_FULL_SCALE + 1);
  localparam int DW  = ((FSW > 10) ? FSW : 10) + 1;
  localparam int NSQ = ntc_pkg::LOG_FRAC_BITS;
  localparam int NQ  = ntc_pkg::QBITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] beta_r, rnom_r, scale_r, rdiv_r, tref_r;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r  <= ntc_pkg::BETA_RST;
      rnom_r  <= ntc_pkg::RNOM_RST;
      scale_r <= ntc_pkg::SCALE_RST;
      rdiv_r  <= ntc_pkg::RDIV_RST;
      tref_r  <= ntc_pkg::TREF_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ntc_pkg::REG_BETA:  beta_r  <= cfg_pwdata[15:0];
        ntc_pkg::REG_RNOM:  rnom_r  <= cfg_pwdata[15:0];
        ntc_pkg::REG_SCALE: scale_r <= cfg_pwdata[15:0];
        ntc_pkg::REG_RDIV:  rdiv_r  <= cfg_pwdata[15:0];
        ntc_pkg::REG_TREF:  tref_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ntc_pkg::REG_BETA:  cfg_prdata = {16'd0, beta_r};
      ntc_pkg::REG_RNOM:  cfg_prdata = {16'd0, rnom_r};
      ntc_pkg::REG_SCALE: cfg_prdata = {16'd0, scale_r};
      ntc_pkg::REG_RDIV:  cfg_prdata = {16'd0, rdiv_r};
      ntc_pkg::REG_TREF:  cfg_prdata = {16'd0, tref_r};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  // Whole pipeline advances unless the output holds a stalled result
  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // --------------------------------------------------------------------------
  // Stage A: inverted count and range checks
  // --------------------------------------------------------------------------
  logic [DW-1:0] d_nxt;
  logic          bad_a_nxt;
  logic          va_r, bad_a_r;
  logic [15:0]   d_r;

  always_comb begin
    d_nxt     = DW'(ADC_FULL_SCALE) - DW'(in_adc_sample);
    bad_a_nxt = (beta_r == 16'd0) || (rnom_r == 16'd0) || (rdiv_r == 16'd0) ||
                (tref_r == 16'd0) || d_nxt[DW-1] || (d_nxt == '0) ||
                (32'(d_nxt) >= 32'(scale_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r    <= in_valid;
      bad_a_r <= bad_a_nxt;
      d_r     <= 16'(d_nxt);
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: divider products (lane 0 numerator side, lane 1 denominator side)
  // --------------------------------------------------------------------------
  logic        vb_r, bad_b_r;
  logic [31:0] n_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r    <= va_r;
      bad_b_r <= bad_a_r;
      n_r[0]  <= d_r * rdiv_r;
      n_r[1]  <= (scale_r - d_r) * rnom_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: normalise to 2^k * m with m in [2^31, 2^32)
  // --------------------------------------------------------------------------
  logic        vsq_r   [NSQ+1];
  logic        bsq_r   [NSQ+1];
  logic [31:0] msq_r   [NSQ+1][2];
  logic [4:0]  ksq_r   [NSQ+1][2];
  logic [NSQ-1:0] fsq_r [NSQ+1][2];

  logic [4:0] k_nxt [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      k_nxt[l] = 5'd0;
      for (int b = 0; b < 32; b++) begin
        if (n_r[l][b]) k_nxt[l] = 5'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsq_r[0] <= 1'b0;
    end else if (en) begin
      vsq_r[0] <= vb_r;
      bsq_r[0] <= bad_b_r;
      for (int l = 0; l < 2; l++) begin
        msq_r[0][l] <= n_r[l] << (5'd31 - k_nxt[l]);
        ksq_r[0][l] <= k_nxt[l];
        fsq_r[0][l] <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Log stages: one squaring per stage yields one fraction bit
  // --------------------------------------------------------------------------
  for (genvar s = 0; s < NSQ; s++) begin : g_sq
    logic [63:0] p [2];
    always_comb begin
      for (int l = 0; l < 2; l++) p[l] = msq_r[s][l] * msq_r[s][l];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vsq_r[s+1] <= 1'b0;
      end else if (en) begin
        vsq_r[s+1] <= vsq_r[s];
        bsq_r[s+1] <= bsq_r[s];
        for (int l = 0; l < 2; l++) begin
          ksq_r[s+1][l] <= ksq_r[s][l];
          if (p[l][63]) begin
            msq_r[s+1][l] <= p[l][63:32];
            fsq_r[s+1][l] <= fsq_r[s][l] | (NSQ'(1) << (NSQ - 1 - s));
          end else begin
            msq_r[s+1][l] <= p[l][62:31];
            fsq_r[s+1][l] <= fsq_r[s][l];
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: log2 times ln2
  // --------------------------------------------------------------------------
  logic        vd_r, bad_d_r;
  logic [62:0] lp_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r    <= vsq_r[NSQ];
      bad_d_r <= bsq_r[NSQ];
      for (int l = 0; l < 2; l++)
        lp_r[l] <= 63'({ksq_r[NSQ][l], fsq_r[NSQ][l]}) * 63'(ntc_pkg::LN2_Q30);
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: round to Q24 and take the difference
  // --------------------------------------------------------------------------
  logic [62:0]        lr0, lr1;
  logic               ve_r, bad_e_r;
  logic signed [29:0] lnv_r;

  assign lr0 = lp_r[0] + (63'd1 << 33);
  assign lr1 = lp_r[1] + (63'd1 << 33);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r    <= vd_r;
      bad_e_r <= bad_d_r;
      lnv_r   <= $signed({1'b0, lr0[62:34]}) - $signed({1'b0, lr1[62:34]});
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: Tref * ln term and Tref * beta
  // --------------------------------------------------------------------------
  logic               vf_r, bad_f_r;
  logic signed [46:0] tl_r;
  logic [31:0]        tb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r    <= ve_r;
      bad_f_r <= bad_e_r;
      tl_r    <= $signed({1'b0, tref_r}) * lnv_r;
      tb_r    <= tref_r * beta_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage G: denominator and numerator of the quotient
  // --------------------------------------------------------------------------
  logic signed [48:0] den_nxt;
  logic [48:0]        base;
  logic               vg_r, bad_g_r;
  logic [47:0]        den_r;
  logic [59:0]        num_r;

  assign base    = (49'(beta_r) * 49'd100) << ntc_pkg::LN_FRAC_BITS;
  assign den_nxt = $signed(base) + 49'(tl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else if (en) begin
      vg_r    <= vf_r;
      bad_g_r <= bad_f_r || den_nxt[48] || (den_nxt == '0);
      den_r   <= den_nxt[47:0];
      num_r   <= (60'(tb_r) * 60'd10) << ntc_pkg::LN_FRAC_BITS;
    end
  end

  // --------------------------------------------------------------------------
  // Division: saturation check, then one quotient bit per stage
  // --------------------------------------------------------------------------
  logic          vq_r   [NQ+1];
  logic          bq_r   [NQ+1];
  logic          sq_r   [NQ+1];
  logic [63:0]   rq_r   [NQ+1];
  logic [47:0]   dq_r   [NQ+1];
  logic [NQ-1:0] qq_r   [NQ+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r[0] <= 1'b0;
    end else if (en) begin
      vq_r[0] <= vg_r;
      bq_r[0] <= bad_g_r;
      sq_r[0] <= 64'(num_r) >= (64'(den_r) << NQ);
      rq_r[0] <= 64'(num_r);
      dq_r[0] <= den_r;
      qq_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < NQ; j++) begin : g_div
    logic [63:0] sh;
    assign sh = 64'(dq_r[j]) << (NQ - 1 - j);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vq_r[j+1] <= 1'b0;
      end else if (en) begin
        vq_r[j+1] <= vq_r[j];
        bq_r[j+1] <= bq_r[j];
        sq_r[j+1] <= sq_r[j];
        dq_r[j+1] <= dq_r[j];
        if (rq_r[j] >= sh) begin
          rq_r[j+1] <= rq_r[j] - sh;
          qq_r[j+1] <= qq_r[j] | (NQ'(1) << (NQ - 1 - j));
        end else begin
          rq_r[j+1] <= rq_r[j];
          qq_r[j+1] <= qq_r[j];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [15:0] temp_r;
  logic        status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vq_r[NQ];
      status_r    <= bq_r[NQ] || sq_r[NQ];
      if (bq_r[NQ])      temp_r <= 16'd0;
      else if (sq_r[NQ]) temp_r <= 16'hFFFF;
      else               temp_r <= 16'(qq_r[NQ]);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_temp_decikelvin = temp_r;
  assign out_status          = status_r;

endmodule
